// ===== rtl/core/gcwg_pkg.sv =====
// Shared types, constants and fixed-point helpers for the great-circle waypoint generator.
`default_nettype none

package gcwg_pkg;

  localparam int LON_W         = 31;
  localparam int LAT_W         = 30;
  localparam int ARG_W         = 34;
  localparam int SQ_W          = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 31;
  localparam int NUM_STEPS_DEF = 100;

  localparam logic signed [ARG_W-1:0] FULL_TURN    = 34'sd1509949440;
  localparam logic signed [ARG_W-1:0] HALF_TURN    = 34'sd754974720;
  localparam logic signed [ARG_W-1:0] QUARTER_TURN = 34'sd377487360;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [30:0] KQ_LO   = 31'd2010228885;
  localparam logic [63:0] RND29   = 64'd536870912;
  localparam logic [63:0] RND31   = 64'd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_LON,
    REG_START_LAT,
    REG_END_LON,
    REG_END_LAT
  } reg_idx_t;

  typedef enum logic [3:0] {
    ARG_SA,
    ARG_CA,
    ARG_SB,
    ARG_CB,
    ARG_DL,
    ARG_S2,
    ARG_S1,
    ARG_MID,
    ARG_MIDC
  } arg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_WRAP,
    OP_WSTORE,
    OP_SIN,
    OP_MUL_C0,
    OP_MUL_C1,
    OP_MUL_T,
    OP_MUL_C2,
    OP_DIV_LD,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_MUL_P0,
    OP_MUL_P1,
    OP_NORM,
    OP_MID,
    OP_FA,
    OP_FB,
    OP_UPD,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    arg_t arg;
    logic final_pt;
  } cmd_t;

  typedef struct packed {
    logic wrap_ok;
    logic sin_done;
    logic div_done;
    logic degen;
    logic bis_open;
    logic out_full;
  } stat_t;

  function automatic logic [7:0] series_div(input logic [2:0] idx);
    case (idx)
      3'd0: return 8'd156;
      3'd1: return 8'd110;
      3'd2: return 8'd72;
      3'd3: return 8'd42;
      3'd4: return 8'd20;
      default: return 8'd6;
    endcase
  endfunction

  function automatic logic [31:0] series_recip(input logic [2:0] idx);
    case (idx)
      3'd0: return 32'd3524075730;
      3'd1: return 32'd2498890063;
      3'd2: return 32'd3817748707;
      3'd3: return 32'd3272355987;
      3'd4: return 32'd3435973836;
      default: return 32'd2863311530;
    endcase
  endfunction

  function automatic logic [5:0] series_shift(input logic [2:0] idx);
    case (idx)
      3'd0: return 6'd39;
      3'd1: return 6'd38;
      3'd2: return 6'd38;
      3'd3: return 6'd37;
      3'd4: return 6'd36;
      default: return 6'd34;
    endcase
  endfunction

  // Q1.30 product, rounded half away from zero.
  function automatic logic signed [SQ_W-1:0] mul_q30(input logic signed [SQ_W-1:0] a,
                                                     input logic signed [SQ_W-1:0] b);
    logic [SQ_W-1:0] ua;
    logic [SQ_W-1:0] ub;
    logic [63:0] p;
    logic [SQ_W-1:0] r;
    ua = a[SQ_W-1] ? SQ_W'(-a) : SQ_W'(a);
    ub = b[SQ_W-1] ? SQ_W'(-b) : SQ_W'(b);
    p = 64'(ua) * 64'(ub);
    r = SQ_W'((p + RND29) >> 30);
    return (a[SQ_W-1] ^ b[SQ_W-1]) ? -$signed(r) : $signed(r);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gcwg_sin.sv =====
// Multi-cycle Q1.30 sine unit: angle wrap, fold, radian scaling and Horner series.
`default_nettype none

module gcwg_sin
  import gcwg_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [ARG_W-1:0] arg,
  output logic                         done,
  output logic signed [SQ_W-1:0]       result
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_FOLD, S_XM, S_X, S_SQ, S_SQR,
    S_T1, S_T2, S_T3, S_T4, S_FIN, S_RND
  } sin_state_t;

  sin_state_t state;
  logic signed [ARG_W-1:0] a;
  logic        neg;
  logic [28:0] m;
  logic [30:0] x;
  logic [31:0] x2;
  logic [30:0] t;
  logic [31:0] p;
  logic [63:0] prod;
  logic [2:0]  idx;

  logic [ARG_W-1:0] mag;
  logic [28:0] fold_m;
  logic [31:0] q0;
  logic [39:0] rem;
  logic [31:0] qc;
  logic [33:0] s_raw;
  logic [30:0] s_clip;

  always_comb begin
    mag = a[ARG_W-1] ? ARG_W'(-a) : ARG_W'(a);
    if (mag > ARG_W'(QUARTER_TURN)) begin
      fold_m = 29'(ARG_W'(HALF_TURN) - mag);
    end else begin
      fold_m = 29'(mag);
    end
    q0 = 32'(prod >> series_shift(idx));
    rem = 40'(p) - 40'(q0) * 40'(series_div(idx));
    qc = (rem >= 40'(series_div(idx))) ? q0 + 32'd1 : q0;
    s_raw = 34'((prod + RND29) >> 30);
    s_clip = (s_raw > 34'(Q30_ONE)) ? Q30_ONE : 31'(s_raw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            a     <= arg;
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (a > HALF_TURN) begin
            a <= a - FULL_TURN;
          end else if (a <= -HALF_TURN) begin
            a <= a + FULL_TURN;
          end else begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          neg   <= a[ARG_W-1];
          m     <= fold_m;
          state <= S_XM;
        end
        S_XM: begin
          prod  <= 64'(m) * 64'(KQ_LO);
          state <= S_X;
        end
        S_X: begin
          x     <= 31'(64'({m, 2'b00}) + ((prod + RND31) >> 32));
          state <= S_SQ;
        end
        S_SQ: begin
          prod  <= 64'(x) * 64'(x);
          state <= S_SQR;
        end
        S_SQR: begin
          x2    <= 32'((prod + RND29) >> 30);
          t     <= Q30_ONE;
          idx   <= 3'd0;
          state <= S_T1;
        end
        S_T1: begin
          prod  <= 64'(x2) * 64'(t);
          state <= S_T2;
        end
        S_T2: begin
          p     <= 32'((prod + RND29) >> 30);
          state <= S_T3;
        end
        S_T3: begin
          prod  <= 64'(p) * 64'(series_recip(idx));
          state <= S_T4;
        end
        S_T4: begin
          t <= Q30_ONE - 31'(qc);
          if (idx == 3'd5) begin
            state <= S_FIN;
          end else begin
            idx   <= idx + 3'd1;
            state <= S_T1;
          end
        end
        S_FIN: begin
          prod  <= 64'(x) * 64'(t);
          state <= S_RND;
        end
        S_RND: begin
          result <= neg ? -$signed(SQ_W'(s_clip)) : $signed(SQ_W'(s_clip));
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gcwg_dp.sv =====
// Datapath: configuration, run coefficients, stride divider, bisection and output register.
`default_nettype none

module gcwg_dp
  import gcwg_pkg::*;
#(
  parameter int NUM_STEPS = NUM_STEPS_DEF
)
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data,
  input  wire cmd_t                         cmd,
  output stat_t                             stat,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [LON_W-1:0]                  out_lon,
  output logic [LAT_W-1:0]                  out_lat,
  output logic                              out_degen,
  output logic                              out_final
);

  localparam int RW = $clog2(NUM_STEPS);
  localparam int DIV_SH = 32 + RW;
  localparam logic [32:0] DIV_RECIP = 33'((64'd1 << DIV_SH) / 64'(NUM_STEPS));

  logic signed [LON_W-1:0] start_lon, end_lon, run_lon1, run_lon2, cur_lon;
  logic signed [LAT_W-1:0] start_lat, end_lat;
  logic signed [ARG_W-1:0] w;
  logic signed [SQ_W-1:0]  stride;
  logic signed [SQ_W-1:0]  sa, ca, sb, cb, sdl, s1, s2, sm, cm;
  logic signed [SQ_W-1:0]  c0, c1, c2, cacb, p0, p1, d;
  logic signed [32:0]      n;
  logic signed [LON_W-1:0] lo, hi, mid;
  logic signed [64:0]      fa, fb;
  logic [31:0]             dvd, quo;
  logic [64:0]             div_prod;
  logic                    dneg;
  logic [5:0]              dcnt;
  arg_t                    arg_q;

  logic                    sin_done;
  logic signed [SQ_W-1:0]  sin_res;
  logic signed [ARG_W-1:0] sin_arg;
  logic signed [ARG_W-1:0] ldiff;
  logic [31:0]             dq0;
  logic [39:0]             drem;
  logic [31:0]             dqc;
  logic signed [32:0]      nn;
  logic [31:0]             span;
  logic                    degen;

  always_comb begin
    case (cmd.arg)
      ARG_SA:   sin_arg = ARG_W'(start_lat);
      ARG_CA:   sin_arg = ARG_W'(start_lat) + QUARTER_TURN;
      ARG_SB:   sin_arg = ARG_W'(end_lat);
      ARG_CB:   sin_arg = ARG_W'(end_lat) + QUARTER_TURN;
      ARG_DL:   sin_arg = ARG_W'(run_lon1) - ARG_W'(run_lon2);
      ARG_S2:   sin_arg = ARG_W'(cur_lon) - ARG_W'(run_lon2);
      ARG_S1:   sin_arg = ARG_W'(cur_lon) - ARG_W'(run_lon1);
      ARG_MID:  sin_arg = ARG_W'(mid);
      ARG_MIDC: sin_arg = ARG_W'(mid) + QUARTER_TURN;
      default:  sin_arg = '0;
    endcase
    ldiff = ARG_W'(run_lon1) - ARG_W'(run_lon2);
    dq0   = 32'(div_prod >> DIV_SH);
    drem  = 40'(dvd) - 40'(dq0) * 40'(NUM_STEPS);
    dqc   = (drem >= 40'(NUM_STEPS)) ? dq0 + 32'd1 : dq0;
    nn    = 33'(p0) - 33'(p1);
    span  = 32'(32'(hi) - 32'(lo) + 32'sd1);
    degen = (c2 == '0);
  end

  assign stat.wrap_ok  = (w > -HALF_TURN) && (w <= HALF_TURN);
  assign stat.sin_done = sin_done;
  assign stat.div_done = (dcnt == 6'd2);
  assign stat.degen    = degen;
  assign stat.bis_open = (lo < hi);
  assign stat.out_full = out_valid && !out_ready;

  gcwg_sin u_sin (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.op == OP_SIN),
    .arg    (sin_arg),
    .done   (sin_done),
    .result (sin_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_lon <= '0;
      start_lat <= '0;
      end_lon   <= '0;
      end_lat   <= '0;
      cur_lon   <= '0;
      stride    <= '0;
      c2        <= '0;
      lo        <= '0;
      hi        <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_START_LON: start_lon <= $signed(cfg_data);
          REG_START_LAT: start_lat <= $signed(cfg_data[LAT_W-1:0]);
          REG_END_LON:   end_lon   <= $signed(cfg_data);
          REG_END_LAT:   end_lat   <= $signed(cfg_data[LAT_W-1:0]);
          default: ;
        endcase
      end

      if (sin_done) begin
        case (arg_q)
          ARG_SA:   sa  <= sin_res;
          ARG_CA:   ca  <= sin_res;
          ARG_SB:   sb  <= sin_res;
          ARG_CB:   cb  <= sin_res;
          ARG_DL:   sdl <= sin_res;
          ARG_S2:   s2  <= sin_res;
          ARG_S1:   s1  <= sin_res;
          ARG_MID:  sm  <= sin_res;
          ARG_MIDC: cm  <= sin_res;
          default: ;
        endcase
      end

      if (out_valid && out_ready && cmd.op != OP_OUT) begin
        out_valid <= 1'b0;
      end

      case (cmd.op)
        OP_LATCH: begin
          run_lon1 <= start_lon;
          run_lon2 <= end_lon;
          w        <= ARG_W'(start_lon);
        end
        OP_WRAP: begin
          if (w > HALF_TURN) begin
            w <= w - FULL_TURN;
          end else if (w <= -HALF_TURN) begin
            w <= w + FULL_TURN;
          end
        end
        OP_WSTORE: cur_lon <= LON_W'(w);
        OP_SIN:    arg_q   <= cmd.arg;
        OP_MUL_C0: c0      <= mul_q30(sa, cb);
        OP_MUL_C1: c1      <= mul_q30(sb, ca);
        OP_MUL_T:  cacb    <= mul_q30(ca, cb);
        OP_MUL_C2: c2      <= mul_q30(cacb, sdl);
        OP_DIV_LD: begin
          dneg <= ldiff[ARG_W-1];
          dvd  <= ldiff[ARG_W-1] ? 32'(-ldiff) : 32'(ldiff);
          quo  <= '0;
          dcnt <= '0;
        end
        OP_DIV_STEP: begin
          if (dcnt == 6'd0) begin
            div_prod <= 65'(dvd) * 65'(DIV_RECIP);
          end else begin
            quo <= dqc;
          end
          dcnt <= dcnt + 6'd1;
        end
        OP_DIV_STORE: stride <= dneg ? -$signed(quo) : $signed(quo);
        OP_MUL_P0: p0 <= mul_q30(c0, s2);
        OP_MUL_P1: p1 <= mul_q30(c1, s1);
        OP_NORM: begin
          if (c2[SQ_W-1]) begin
            d <= -c2;
            n <= -nn;
          end else begin
            d <= c2;
            n <= nn;
          end
          lo <= LON_W'(-QUARTER_TURN);
          hi <= LON_W'(QUARTER_TURN);
        end
        OP_MID: mid <= lo + LON_W'(span >> 1);
        OP_FA:  fa  <= 65'(sm) * 65'(d);
        OP_FB:  fb  <= 65'(cm) * 65'(n);
        OP_UPD: begin
          if (fa <= fb) begin
            lo <= mid;
          end else begin
            hi <= mid - 31'sd1;
          end
        end
        OP_OUT: begin
          out_valid <= 1'b1;
          out_lon   <= cur_lon;
          out_lat   <= degen ? '0 : LAT_W'(lo);
          out_degen <= degen;
          out_final <= cmd.final_pt;
          w         <= ARG_W'(cur_lon) - ARG_W'(stride);
        end
        default: ;
      endcase
    end
  end

  a_degen_lat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_degen |-> out_lat == '0)
    else $error("degenerate waypoint carries a nonzero latitude");

  a_bis_order: assert property (@(posedge clk) disable iff (rst)
    lo <= hi)
    else $error("bisection bounds crossed");

  a_wrap_store: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_WSTORE |-> stat.wrap_ok)
    else $error("longitude stored before wrap finished");

  a_out_safe: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT |-> !(out_valid && !out_ready))
    else $error("waypoint overwrote an untaken result");

endmodule

`default_nettype wire

// ===== rtl/core/gcwg_ctrl.sv =====
// Controller: sequences reload, latitude solve, output and longitude step for each tick.
`default_nettype none

module gcwg_ctrl
  import gcwg_pkg::*;
#(
  parameter int NUM_STEPS = NUM_STEPS_DEF
)
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  in_restart,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  localparam int SCW = $clog2(NUM_STEPS);

  typedef enum logic [4:0] {
    C_IDLE, C_LATCH, C_RWRAP, C_SIN, C_SINW, C_MULC0, C_MULC1, C_MULT, C_MULC2,
    C_DIVLD, C_DIV, C_CHECK, C_P0, C_P1, C_NORM, C_BIS, C_FA, C_FB, C_UPD,
    C_OUT, C_SWRAP
  } ctrl_state_t;

  ctrl_state_t state, state_next;
  arg_t        sarg, sarg_next;
  logic [SCW-1:0] step_cnt;
  logic        reload_due;
  logic        final_pt;

  assign final_pt = (step_cnt == SCW'(NUM_STEPS - 1));
  assign in_ready = (state == C_IDLE);

  always_comb begin
    state_next   = state;
    sarg_next    = sarg;
    cmd.op       = OP_NONE;
    cmd.arg      = sarg;
    cmd.final_pt = final_pt;
    case (state)
      C_IDLE: begin
        if (in_valid) begin
          state_next = (in_restart || reload_due) ? C_LATCH : C_CHECK;
        end
      end
      C_LATCH: begin
        cmd.op     = OP_LATCH;
        state_next = C_RWRAP;
      end
      C_RWRAP: begin
        if (stat.wrap_ok) begin
          cmd.op     = OP_WSTORE;
          sarg_next  = ARG_SA;
          state_next = C_SIN;
        end else begin
          cmd.op = OP_WRAP;
        end
      end
      C_SIN: begin
        cmd.op     = OP_SIN;
        state_next = C_SINW;
      end
      C_SINW: begin
        if (stat.sin_done) begin
          case (sarg)
            ARG_SA:   begin sarg_next = ARG_CA;   state_next = C_SIN;   end
            ARG_CA:   begin sarg_next = ARG_SB;   state_next = C_SIN;   end
            ARG_SB:   begin sarg_next = ARG_CB;   state_next = C_SIN;   end
            ARG_CB:   begin sarg_next = ARG_DL;   state_next = C_SIN;   end
            ARG_DL:   state_next = C_MULC0;
            ARG_S2:   begin sarg_next = ARG_S1;   state_next = C_SIN;   end
            ARG_S1:   state_next = C_P0;
            ARG_MID:  begin sarg_next = ARG_MIDC; state_next = C_SIN;   end
            ARG_MIDC: state_next = C_FA;
            default:  state_next = C_IDLE;
          endcase
        end
      end
      C_MULC0: begin cmd.op = OP_MUL_C0; state_next = C_MULC1; end
      C_MULC1: begin cmd.op = OP_MUL_C1; state_next = C_MULT;  end
      C_MULT:  begin cmd.op = OP_MUL_T;  state_next = C_MULC2; end
      C_MULC2: begin cmd.op = OP_MUL_C2; state_next = C_DIVLD; end
      C_DIVLD: begin cmd.op = OP_DIV_LD; state_next = C_DIV;   end
      C_DIV: begin
        if (stat.div_done) begin
          cmd.op     = OP_DIV_STORE;
          state_next = C_CHECK;
        end else begin
          cmd.op = OP_DIV_STEP;
        end
      end
      C_CHECK: begin
        if (stat.degen) begin
          state_next = C_OUT;
        end else begin
          sarg_next  = ARG_S2;
          state_next = C_SIN;
        end
      end
      C_P0:   begin cmd.op = OP_MUL_P0; state_next = C_P1;   end
      C_P1:   begin cmd.op = OP_MUL_P1; state_next = C_NORM; end
      C_NORM: begin cmd.op = OP_NORM;   state_next = C_BIS;  end
      C_BIS: begin
        if (stat.bis_open) begin
          cmd.op     = OP_MID;
          sarg_next  = ARG_MID;
          state_next = C_SIN;
        end else begin
          state_next = C_OUT;
        end
      end
      C_FA:  begin cmd.op = OP_FA;  state_next = C_FB;  end
      C_FB:  begin cmd.op = OP_FB;  state_next = C_UPD; end
      C_UPD: begin cmd.op = OP_UPD; state_next = C_BIS; end
      C_OUT: begin
        if (!stat.out_full) begin
          cmd.op     = OP_OUT;
          state_next = C_SWRAP;
        end
      end
      C_SWRAP: begin
        if (stat.wrap_ok) begin
          cmd.op     = OP_WSTORE;
          state_next = C_IDLE;
        end else begin
          cmd.op = OP_WRAP;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= C_IDLE;
      sarg       <= ARG_SA;
      step_cnt   <= '0;
      reload_due <= 1'b0;
    end else begin
      state <= state_next;
      sarg  <= sarg_next;
      if (state == C_LATCH) begin
        step_cnt   <= '0;
        reload_due <= 1'b0;
      end
      if (state == C_OUT && !stat.out_full) begin
        if (final_pt) begin
          step_cnt   <= '0;
          reload_due <= 1'b1;
        end else begin
          step_cnt <= step_cnt + SCW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/great_circle_waypoint_generator.sv =====
// Operation: the shared sine unit runs twice in each of about 30 latitude bisection steps;
// a run reload adds five sine calls and the stride division, and a degenerate waypoint
// skips the bisection.
// Throughput: one waypoint at a time; the next tick is taken once the current longitude
// step is stored, while the previous waypoint may still wait in the output register.
// Reset: synchronous, active high; clears the configuration, run state and the output valid.
`default_nettype none

module great_circle_waypoint_generator
  import gcwg_pkg::*;
#(
  parameter int NUM_STEPS = NUM_STEPS_DEF
)
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // [0] restart
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [63:0]                 m_axis_tdata,   // [30:0] way_lon, [60:31] way_lat
  output logic                        m_axis_tuser,   // [0] degenerate
  output logic                        m_axis_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t cmd;
  stat_t stat;
  logic [LON_W-1:0] out_lon;
  logic [LAT_W-1:0] out_lat;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {3'b000, out_lat, out_lon};

  gcwg_ctrl #(.NUM_STEPS(NUM_STEPS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_restart (s_axis_tdata[0]),
    .cmd        (cmd),
    .stat       (stat)
  );

  gcwg_dp #(.NUM_STEPS(NUM_STEPS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_lon   (out_lon),
    .out_lat   (out_lat),
    .out_degen (m_axis_tuser),
    .out_final (m_axis_tlast)
  );

endmodule

`default_nettype wire
